// ===== rtl/lrmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrmr_pkg
// Shared constants for the rounded linear range mapper: default width,
// register map and register reset values.
// ----------------------------------------------------------------------------
package lrmr_pkg;

   localparam int DATA_WIDTH_DEF = 16;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_SRC_START = 2'd0;
   localparam logic [1:0] REG_SRC_END   = 2'd1;
   localparam logic [1:0] REG_DST_START = 2'd2;
   localparam logic [1:0] REG_DST_END   = 2'd3;

   localparam int RST_SRC_START = 0;
   localparam int RST_SRC_END   = 255;
   localparam int RST_DST_START = 0;
   localparam int RST_DST_END   = 100;

endpackage

// ===== rtl/linear_range_map_rounded_core.sv =====
// ----------------------------------------------------------------------------
// linear_range_map_rounded_core
// Clamps a signed sample to the source range and maps it linearly to the
// target range, rounding half away from zero.
// Throughput: one item per cycle; a restoring divider with one quotient bit
// per pipeline stage sets the depth.
// The whole pipeline holds while the output item is stalled.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module linear_range_map_rounded_core #(
   parameter int DATA_WIDTH = lrmr_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [DATA_WIDTH-1:0]        rsp_mapped_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lrmr_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [lrmr_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [lrmr_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   localparam int W      = DATA_WIDTH;
   localparam int NSTAGE = W + 5;
   localparam int OUTST  = W + 4;

   // configuration
   logic signed [W-1:0] src_start_ff, src_end_ff, dst_start_ff, dst_end_ff;
   logic                wr_en;
   logic [1:0]          reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_start_ff <= W'(lrmr_pkg::RST_SRC_START);
         src_end_ff   <= W'(lrmr_pkg::RST_SRC_END);
         dst_start_ff <= W'(lrmr_pkg::RST_DST_START);
         dst_end_ff   <= W'(lrmr_pkg::RST_DST_END);
      end else if (wr_en) begin
         case (reg_idx)
            lrmr_pkg::REG_SRC_START: src_start_ff <= pwdata[W-1:0];
            lrmr_pkg::REG_SRC_END:   src_end_ff   <= pwdata[W-1:0];
            lrmr_pkg::REG_DST_START: dst_start_ff <= pwdata[W-1:0];
            lrmr_pkg::REG_DST_END:   dst_end_ff   <= pwdata[W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         lrmr_pkg::REG_SRC_START: prdata[W-1:0] = src_start_ff;
         lrmr_pkg::REG_SRC_END:   prdata[W-1:0] = src_end_ff;
         lrmr_pkg::REG_DST_START: prdata[W-1:0] = dst_start_ff;
         lrmr_pkg::REG_DST_END:   prdata[W-1:0] = dst_end_ff;
         default:                 prdata = '0;
      endcase
   end

   // derived constants, used from the second stage on
   logic signed [W:0] sdiff, ddiff;
   logic [W-1:0]      dmag_in, dmag_ff, bmag_in, bmag_ff;
   logic              neg_ff, empty_ff;

   assign sdiff   = {src_end_ff[W-1], src_end_ff} - {src_start_ff[W-1], src_start_ff};
   assign ddiff   = {dst_end_ff[W-1], dst_end_ff} - {dst_start_ff[W-1], dst_start_ff};
   assign dmag_in = sdiff[W] ? W'(-sdiff) : sdiff[W-1:0];
   assign bmag_in = ddiff[W] ? W'(-ddiff) : ddiff[W-1:0];

   always_ff @(posedge clock) begin
      dmag_ff  <= dmag_in;
      bmag_ff  <= bmag_in;
      neg_ff   <= ddiff[W];
      empty_ff <= (src_start_ff == src_end_ff);
   end

   // pipeline control
   logic              adv;
   logic [NSTAGE-1:0] vld_ff;

   assign adv       = !(vld_ff[OUTST] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[OUTST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   // stage 0: clamp
   logic signed [W-1:0] lo, hi, vc_in, vc_ff;

   assign lo = (src_start_ff < src_end_ff) ? src_start_ff : src_end_ff;
   assign hi = (src_start_ff < src_end_ff) ? src_end_ff : src_start_ff;

   always_comb begin
      vc_in = req_sample_in;
      if (req_sample_in < lo) begin
         vc_in = lo;
      end else if (req_sample_in > hi) begin
         vc_in = hi;
      end
   end

   // stage 1: offset magnitude
   logic signed [W:0] adiff;
   logic [W-1:0]      amag_ff, bsel_ff;

   assign adiff = {vc_ff[W-1], vc_ff} - {src_start_ff[W-1], src_start_ff};

   // stage 2: product, stage 3: rounding bias and divider entry
   logic [2*W-1:0] prod_ff;
   logic [2*W-1:0] num;

   assign num = prod_ff + {(W+1)'(0), dmag_ff[W-1:1]};

   logic [W-1:0] rem_ff [0:W];
   logic [W-1:0] nlo_ff [0:W];
   logic [W-1:0] quo_ff [0:W];

   always_ff @(posedge clock) begin
      if (adv) begin
         vc_ff     <= vc_in;
         amag_ff   <= adiff[W] ? W'(-adiff) : adiff[W-1:0];
         bsel_ff   <= bmag_ff;
         prod_ff   <= {W'(0), amag_ff} * {W'(0), bsel_ff};
         rem_ff[0] <= num[2*W-1:W];
         nlo_ff[0] <= num[W-1:0];
         quo_ff[0] <= '0;
      end
   end

   // divider: one quotient bit per stage, msb first
   for (genvar j = 0; j < W; j++) begin : g_div
      localparam int BIT = W - 1 - j;
      logic [W:0]   trial;
      logic [W:0]   sub;
      logic         take;
      logic [W-1:0] q_in;

      assign trial = {rem_ff[j], nlo_ff[j][BIT]};
      assign sub   = trial - {1'b0, dmag_ff};
      assign take  = (trial >= {1'b0, dmag_ff});

      always_comb begin
         q_in      = quo_ff[j];
         q_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= take ? sub[W-1:0] : trial[W-1:0];
            nlo_ff[j+1] <= nlo_ff[j];
            quo_ff[j+1] <= q_in;
         end
      end
   end

   // output stage
   logic signed [W-1:0] out_in, out_ff;

   always_comb begin
      if (empty_ff) begin
         out_in = dst_start_ff;
      end else if (neg_ff) begin
         out_in = dst_start_ff - quo_ff[W];
      end else begin
         out_in = dst_start_ff + quo_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_mapped_out = out_ff;

endmodule
